[sv/usw_pkg.sv]
// Package for the URL suffix whitelist match unit: constants, types and codes.
`timescale 1ns / 1ps
package usw_pkg;

   localparam int SUFFIX_SLOTS = 7;
   localparam int SUFFIX_BYTES = 8;
   localparam int MAX_GAP      = 100;

   localparam int CHAR_W   = 8;
   localparam int SLOT_W   = SUFFIX_BYTES * CHAR_W;
   // suffix length saturates at SUFFIX_BYTES + 1 (too long to match)
   localparam int SLEN_W   = $clog2(SUFFIX_BYTES + 2);
   localparam int GAP_W    = $clog2(MAX_GAP + 1);
   localparam int COUNT_W  = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_QUERY = 8'h3F;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SUFFIX_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SUFFIX_FIRST = 3'd1;

   typedef enum logic [1:0] {
      MARK_NONE  = 2'd0,
      MARK_SLASH = 2'd1,
      MARK_DOT   = 2'd2
   } mark_kind_type;

   typedef logic [SLOT_W-1:0] slot_type;
   typedef slot_type [SUFFIX_SLOTS-1:0] slot_array_type;

   // what the compare stage needs from a finished URL
   typedef struct packed {
      logic              shape_ok;  // length, final mark and segment lengths all fine
      logic [SLOT_W-1:0] bytes;
      logic [SLEN_W-1:0] len;
   } url_snap_type;

endpackage

[sv/url_suffix_whitelist_match_unit.sv]
// Top level of the URL suffix whitelist match unit.
// Usage:
//  - req_ carries one URL byte per beat (tdata) with tlast on the final byte.
//  - rsp_ carries one verdict per URL, rsp_tdata[0] = 1 for rejected, 0 for accepted.
//  - csr_ writes the slot count (index 0) and suffix slots (indexes 1 to 7);
//    only write while no URL is in flight. csr_ready is always high.
// Pipeline and flow:
//  - One byte per cycle while req_tready is high. Per-URL state updates on each
//    accepted beat; on the last beat the finished suffix is snapshotted into a
//    compare stage, and the verdict then moves into the output register when
//    that register is empty or being taken, which raises rsp_tvalid.
//  - The compare stage and the output register form a two-deep pipe, so the
//    next URL keeps streaming while a verdict waits to be taken.
// Reset (synchronous, active high) clears URL state, pending verdicts, the
// slot count and all slots. If rsp_tready stays low, both verdict stages fill
// and req_tready drops until the output register drains.
`timescale 1ns / 1ps
module url_suffix_whitelist_match_unit (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [7:0] character
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: [0] rejected, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [usw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [usw_pkg::CSR_DATA_W-1:0] csr_data
);
   import usw_pkg::*;

   // configuration
   logic [COUNT_W-1:0] count_ff;
   slot_array_type     slots_ff;

   // per-URL running state
   mark_kind_type      mark_ff, mark_in;
   logic [SLOT_W-1:0]  bytes_ff, bytes_in;
   logic [SLEN_W-1:0]  slen_ff, slen_in;
   logic               query_ff, query_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic               trip_ff, trip_in;
   logic [1:0]         len_ff, len_in;

   // compare stage and output register
   logic               s1_valid_ff, s1_valid_in;
   url_snap_type       snap_ff, snap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rejected_ff, rejected_in;

   logic               beat, last_beat, rsp_load, accept;
   logic [GAP_W-1:0]   gap_step;

   assign csr_ready  = 1'b1;
   assign rsp_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || rsp_load;
   assign beat       = req_tvalid && req_tready;
   assign last_beat  = beat && req_tlast;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         slots_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_SUFFIX_COUNT) begin
            count_ff <= csr_data[COUNT_W-1:0];
         end else begin
            for (int k = 0; k < SUFFIX_SLOTS; k++) begin
               if (int'(csr_index) - int'(REG_SUFFIX_FIRST) == k) begin
                  slots_ff[k] <= csr_data[SLOT_W-1:0];
               end
            end
         end
      end
   end

   // saturating count of the current segment
   assign gap_step = (int'(gap_ff) < MAX_GAP) ? gap_ff + 1'b1 : gap_ff;

   always_comb begin
      mark_in  = mark_ff;
      bytes_in = bytes_ff;
      slen_in  = slen_ff;
      query_in = query_ff;
      gap_in   = gap_ff;
      trip_in  = trip_ff;
      len_in   = (len_ff < 2'd2) ? len_ff + 1'b1 : len_ff;

      if (req_tdata == CH_SLASH) begin
         mark_in = MARK_SLASH;
      end else if (req_tdata == CH_DOT) begin
         mark_in  = MARK_DOT;
         bytes_in = SLOT_W'(CH_DOT);
         slen_in  = SLEN_W'(1);
         query_in = 1'b0;
         gap_in   = GAP_W'(1);
         trip_in  = 1'b0;
      end else if (mark_ff == MARK_DOT) begin
         if (req_tdata == CH_QUERY) begin
            query_in = 1'b1;
            gap_in   = GAP_W'(1);
         end else begin
            gap_in  = gap_step;
            trip_in = trip_ff || (int'(gap_step) >= MAX_GAP);
            if (!query_ff && int'(slen_ff) <= SUFFIX_BYTES) begin
               for (int b = 0; b < SUFFIX_BYTES; b++) begin
                  if (b == int'(slen_ff)) begin
                     bytes_in[b*CHAR_W +: CHAR_W] = req_tdata;
                  end
               end
               slen_in = slen_ff + 1'b1;
            end
         end
      end

      snap_in.shape_ok = (len_in == 2'd2) && (mark_in == MARK_DOT) && !trip_in;
      snap_in.bytes    = bytes_in;
      snap_in.len      = slen_in;
   end

   always_ff @(posedge clock) begin
      if (reset || last_beat) begin
         mark_ff  <= MARK_NONE;
         bytes_ff <= '0;
         slen_ff  <= '0;
         query_ff <= 1'b0;
         gap_ff   <= '0;
         trip_ff  <= 1'b0;
         len_ff   <= '0;
      end else if (beat) begin
         mark_ff  <= mark_in;
         bytes_ff <= bytes_in;
         slen_ff  <= slen_in;
         query_ff <= query_in;
         gap_ff   <= gap_in;
         trip_ff  <= trip_in;
         len_ff   <= len_in;
      end
   end

   usw_match u_match (
      .snap       (snap_ff),
      .slots      (slots_ff),
      .slot_count (count_ff),
      .accept     (accept)
   );

   always_comb begin
      s1_valid_in  = last_beat ? 1'b1 : (rsp_load ? 1'b0 : s1_valid_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      rejected_in  = rsp_load ? !accept : rejected_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_beat) begin
         snap_ff <= snap_in;
      end
      rejected_ff <= rejected_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rejected_ff};

   a_last_fills_stage : assert property (@(posedge clock) disable iff (reset)
      last_beat |=> s1_valid_ff)
      else $error("last beat did not reach the compare stage");

   a_url_state_cleared : assert property (@(posedge clock) disable iff (reset)
      last_beat |=> (len_ff == 2'd0) && (mark_ff == MARK_NONE) && (slen_ff == '0))
      else $error("URL state not cleared after last beat");

   a_slen_bound : assert property (@(posedge clock) disable iff (reset)
      int'(slen_ff) <= SUFFIX_BYTES + 1)
      else $error("suffix length past saturation");

   a_slen_needs_mark : assert property (@(posedge clock) disable iff (reset)
      (slen_ff != '0) |-> (mark_ff != MARK_NONE))
      else $error("suffix captured without a mark");

endmodule

[sv/usw_match.sv]
// Parallel compare of a captured suffix against all configured slots.
`timescale 1ns / 1ps
module usw_match (
   input  usw_pkg::url_snap_type   snap,
   input  usw_pkg::slot_array_type slots,
   input  logic [usw_pkg::COUNT_W-1:0] slot_count,
   output logic                    accept
);
   import usw_pkg::*;

   logic [SUFFIX_SLOTS-1:0] hit;
   logic                    len_ok;

   assign len_ok = (snap.len != '0) && (int'(snap.len) <= SUFFIX_BYTES);

   always_comb begin
      logic bad;
      for (int k = 0; k < SUFFIX_SLOTS; k++) begin
         bad = 1'b0;
         for (int b = 0; b < SUFFIX_BYTES; b++) begin
            // captured lanes past the length are zero, so the slot's byte just
            // after the suffix must be padding
            if (b < int'(snap.len)) begin
               if (slots[k][b*CHAR_W +: CHAR_W] != snap.bytes[b*CHAR_W +: CHAR_W]) begin
                  bad = 1'b1;
               end
            end else if (b == int'(snap.len)) begin
               if (slots[k][b*CHAR_W +: CHAR_W] != '0) begin
                  bad = 1'b1;
               end
            end
         end
         hit[k] = (k < int'(slot_count)) && len_ok && !bad;
      end
   end

   assign accept = snap.shape_ok && (|hit);

endmodule
